// ----- hdl/rbrs_pkg.sv -----
// Shared types, constants and a helper function for the robot bridge register block.
// No dependencies; the core, datapath, controller and verification files import it.
`default_nettype none

package rbrs_pkg;

   // Field widths that the bus and sensor formats fix.
   localparam int unsigned DIST_W  = 12;
   localparam int unsigned DRIVE_W = 9;

   // Default depth of the distance averaging ring.
   localparam int unsigned AVG_DEPTH_DEFAULT = 5;

   // Limits and reset values.
   localparam logic [15:0] SAMPLE_MAX   = 16'd4000;
   localparam logic [15:0] STOP_MIN     = 16'd30;
   localparam logic [15:0] STOP_RESET   = 16'd120;
   localparam logic [15:0] RESUME_RESET = 16'd180;
   localparam logic signed [15:0] DRIVE_MAX = 16'sd255;
   localparam logic [15:0] ID_WORD      = 16'h424D;

   // Transaction kinds.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Payload and response byte counts.
   localparam logic [1:0] LEN_NONE = 2'd0;
   localparam logic [1:0] LEN_ONE  = 2'd1;
   localparam logic [1:0] LEN_TWO  = 2'd2;

   // Register map.
   localparam logic [7:0] REG_ID     = 8'h00;
   localparam logic [7:0] REG_LEFT   = 8'h01;
   localparam logic [7:0] REG_RIGHT  = 8'h03;
   localparam logic [7:0] REG_DIST   = 8'h05;
   localparam logic [7:0] REG_FLAGS  = 8'h07;
   localparam logic [7:0] REG_OPTS   = 8'h08;
   localparam logic [7:0] REG_STOP   = 8'h09;
   localparam logic [7:0] REG_RESUME = 8'h0B;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic do_write;
      logic ring_store;
      logic dist_clear;
      logic sum_step;
      logic div_start;
      logic div_take;
      logic finish;
      logic load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] cmd;
      logic       sample_ok;
      logic       sum_last;
      logic       div_done;
      logic       rsp_free;
   } ctrl_status_type;

   // Saturates a 16-bit two's complement speed to the motor drive range.
   function automatic logic signed [DRIVE_W-1:0] clamp_speed(input logic [15:0] raw);
      logic signed [15:0] v;
      v = signed'(raw);
      if (v > DRIVE_MAX) begin
         return DRIVE_W'(DRIVE_MAX);
      end else if (v < -DRIVE_MAX) begin
         return DRIVE_W'(-DRIVE_MAX);
      end else begin
         return signed'(v[DRIVE_W-1:0]);
      end
   endfunction

endpackage

`default_nettype wire

// ----- hdl/rbrs_if.sv -----
// Valid/ready channel interfaces for the request and response transactions.
// No dependencies.
`default_nettype none

interface rbrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [7:0]  reg_addr;
   logic [1:0]  write_len;
   logic [15:0] write_data;
   logic [15:0] sample_mm;

   modport source (output valid, cmd, reg_addr, write_len, write_data, sample_mm,
                   input ready);
   modport sink   (input valid, cmd, reg_addr, write_len, write_data, sample_mm,
                   output ready);
endinterface

interface rbrs_rsp_if;
   logic              valid;
   logic              ready;
   logic [15:0]       read_data;
   logic [1:0]        read_len;
   logic signed [8:0] left_drive;
   logic signed [8:0] right_drive;
   logic [2:0]        status_bits;

   modport source (output valid, read_data, read_len, left_drive, right_drive, status_bits,
                   input ready);
   modport sink   (input valid, read_data, read_len, left_drive, right_drive, status_bits,
                   output ready);
endinterface

`default_nettype wire

// ----- hdl/robot_bridge_registers_with_safety_core.sv -----
// Robot bridge register block: bus register file, distance averaging and safety stop.
// Takes one request transaction on req_ch and returns exactly one response on rsp_ch.
// A bus write selects a register and may store motor speeds, options or thresholds.
// A bus read returns the selected register; a sensor tick filters a sample in
// millimetres, updates the hysteresis stop latch and sets both motor drives.
// Every response also carries the current drives and the three status bits.
// Requests are taken one at a time: req_ch.ready is high only while the controller
// is idle. Writes, reads and unused commands go from decode straight to the output
// state. A tick with a valid sample stores it in the ring, sums the n samples held
// there (up to AVG_DEPTH) and forms the mean in a bit-serial divider that works
// through the sample sum bit by bit (15 bits for five samples). An invalid sample
// clears the distance and skips the ring and the divider.
// The response sits in an output register, so a new request is accepted while the
// previous response still waits; if the receiver stalls, the following response is
// held back until that register is free. Reset is synchronous: it restores the
// register defaults (stop 120, resume 180), empties the ring and clears all drives.
// Depends on rbrs_pkg, rbrs_if, rbrs_ctrl, rbrs_dpath and rbrs_div.
`default_nettype none

module robot_bridge_registers_with_safety_core #(
   parameter int unsigned AVG_DEPTH = rbrs_pkg::AVG_DEPTH_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   rbrs_req_if.sink   req_ch,
   rbrs_rsp_if.source rsp_ch
);

   import rbrs_pkg::*;

   ctrl_cmd_type    ctl_cmd;
   ctrl_status_type ctl_stat;

   rbrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .ctl_stat  (ctl_stat),
      .ctl_cmd   (ctl_cmd)
   );

   rbrs_dpath #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl_cmd         (ctl_cmd),
      .ctl_stat        (ctl_stat),
      .req_cmd         (req_ch.cmd),
      .req_reg_addr    (req_ch.reg_addr),
      .req_write_len   (req_ch.write_len),
      .req_write_data  (req_ch.write_data),
      .req_sample_mm   (req_ch.sample_mm),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_read_data   (rsp_ch.read_data),
      .rsp_read_len    (rsp_ch.read_len),
      .rsp_left_drive  (rsp_ch.left_drive),
      .rsp_right_drive (rsp_ch.right_drive),
      .rsp_status_bits (rsp_ch.status_bits)
   );

endmodule

`default_nettype wire

// ----- hdl/rbrs_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// No package dependencies; used by the datapath for the distance mean.
`default_nettype none

module rbrs_div #(
   parameter int unsigned DVD_W = 16,
   parameter int unsigned DVS_W = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int unsigned CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] q_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   trial;
   logic             fits;
   logic [DVS_W-1:0] rem_in;

   // Trial subtraction of the divisor from the shifted partial remainder.
   always_comb begin
      trial  = {rem_ff, q_ff[DVD_W-1]};
      fits   = (trial >= {1'b0, dvs_ff});
      rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
   end

   // Sequencing: a step per cycle, with a pulse once the last bit is in.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Dividend shifts out at the top while quotient bits shift in at the bottom.
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[DVD_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// ----- hdl/rbrs_dpath.sv -----
// Datapath: bus registers, sample ring, accumulator, safety latch and response register.
// Depends on rbrs_pkg and instantiates rbrs_div.
`default_nettype none

module rbrs_dpath #(
   parameter int unsigned AVG_DEPTH = rbrs_pkg::AVG_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rbrs_pkg::ctrl_cmd_type  ctl_cmd,
   output rbrs_pkg::ctrl_status_type    ctl_stat,
   input  wire logic [1:0]              req_cmd,
   input  wire logic [7:0]              req_reg_addr,
   input  wire logic [1:0]              req_write_len,
   input  wire logic [15:0]             req_write_data,
   input  wire logic [15:0]             req_sample_mm,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic [15:0]                  rsp_read_data,
   output logic [1:0]                   rsp_read_len,
   output logic signed [8:0]            rsp_left_drive,
   output logic signed [8:0]            rsp_right_drive,
   output logic [2:0]                   rsp_status_bits
);

   import rbrs_pkg::*;

   localparam int unsigned IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(AVG_DEPTH + 1);
   localparam int unsigned SUM_W = $clog2(AVG_DEPTH * SAMPLE_MAX + 1);

   // Captured transaction.
   logic [1:0]  cmd_ff;
   logic [7:0]  addr_ff;
   logic [1:0]  wlen_ff;
   logic [15:0] wdata_ff;
   logic [15:0] sample_ff;

   // Architectural registers.
   logic [7:0]                selected_ff,  selected_in;
   logic signed [DRIVE_W-1:0] left_cmd_ff,  left_cmd_in;
   logic signed [DRIVE_W-1:0] right_cmd_ff, right_cmd_in;
   logic [7:0]                opt_ff,       opt_in;
   logic [15:0]               stop_ff,      stop_in;
   logic [15:0]               resume_ff,    resume_in;
   logic [DIST_W-1:0]         filt_ff,      filt_in;
   logic [2:0]                flag_ff,      flag_in;
   logic [IDX_W-1:0]          pos_ff,       pos_in;
   logic                      full_ff,      full_in;
   logic                      latch_ff,     latch_in;
   logic signed [DRIVE_W-1:0] left_out_ff,  left_out_in;
   logic signed [DRIVE_W-1:0] right_out_ff, right_out_in;

   // Averaging.
   logic [DIST_W-1:0] ring_ff [AVG_DEPTH];
   logic [IDX_W-1:0]  sum_idx_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]  count;
   logic              div_done;
   logic [SUM_W-1:0]  quotient;

   // Response register.
   logic              rsp_valid_ff;
   logic [15:0]       rsp_data_ff;
   logic [1:0]        rsp_len_ff;
   logic signed [8:0] rsp_left_ff;
   logic signed [8:0] rsp_right_ff;
   logic [2:0]        rsp_flag_ff;

   logic [15:0]               rd_data;
   logic [1:0]                rd_len;
   logic [1:0]                wlen_eff;
   logic                      sample_ok;
   logic [15:0]               dist_wide;
   logic                      latch_nx;
   logic signed [DRIVE_W-1:0] left_sel;
   logic signed [DRIVE_W-1:0] right_sel;

   // Transaction capture.
   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         cmd_ff    <= req_cmd;
         addr_ff   <= req_reg_addr;
         wlen_ff   <= req_write_len;
         wdata_ff  <= req_write_data;
         sample_ff <= req_sample_mm;
      end
   end

   assign sample_ok = (sample_ff != 16'd0) && (sample_ff <= SAMPLE_MAX);
   assign wlen_eff  = (wlen_ff > LEN_TWO) ? LEN_TWO : wlen_ff;
   assign count     = full_ff ? CNT_W'(AVG_DEPTH) : CNT_W'(pos_ff);
   assign dist_wide = {{(16 - DIST_W){1'b0}}, filt_ff};

   // Hysteresis latch and drive selection used at the end of a tick.
   always_comb begin
      if (!opt_ff[2]) begin
         latch_nx = 1'b0;
      end else if (flag_ff[0]) begin
         latch_nx = latch_ff ? !(dist_wide >= resume_ff) : (dist_wide <= stop_ff);
      end else begin
         latch_nx = latch_ff;
      end
      left_sel  = opt_ff[0] ? -left_cmd_ff  : left_cmd_ff;
      right_sel = opt_ff[1] ? -right_cmd_ff : right_cmd_ff;
   end

   // Next values of the architectural registers.
   always_comb begin
      selected_in  = selected_ff;
      left_cmd_in  = left_cmd_ff;
      right_cmd_in = right_cmd_ff;
      opt_in       = opt_ff;
      stop_in      = stop_ff;
      resume_in    = resume_ff;
      filt_in      = filt_ff;
      flag_in      = flag_ff;
      pos_in       = pos_ff;
      full_in      = full_ff;
      latch_in     = latch_ff;
      left_out_in  = left_out_ff;
      right_out_in = right_out_ff;

      // Bus write: select, then store where the register and length allow it.
      if (ctl_cmd.do_write) begin
         selected_in = addr_ff;
         if (wlen_eff != LEN_NONE) begin
            if (addr_ff == REG_OPTS) begin
               opt_in = wdata_ff[7:0];
            end else if (wlen_eff == LEN_TWO) begin
               if (addr_ff == REG_LEFT) begin
                  left_cmd_in = clamp_speed(wdata_ff);
               end else if (addr_ff == REG_RIGHT) begin
                  right_cmd_in = clamp_speed(wdata_ff);
               end else if (addr_ff == REG_STOP) begin
                  stop_in = (wdata_ff < STOP_MIN) ? STOP_MIN : wdata_ff;
               end else if (addr_ff == REG_RESUME) begin
                  resume_in = (wdata_ff < stop_ff) ? stop_ff : wdata_ff;
               end
            end
         end
      end

      // Valid sample advances the ring position.
      if (ctl_cmd.ring_store) begin
         if (pos_ff == IDX_W'(AVG_DEPTH - 1)) begin
            pos_in  = '0;
            full_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end

      // Invalid sample drops the distance.
      if (ctl_cmd.dist_clear) begin
         filt_in    = '0;
         flag_in[0] = 1'b0;
      end

      // Mean is ready.
      if (ctl_cmd.div_take) begin
         filt_in    = quotient[DIST_W-1:0];
         flag_in[0] = 1'b1;
      end

      // Safety latch, status and motor drive.
      if (ctl_cmd.finish) begin
         latch_in   = latch_nx;
         flag_in[1] = opt_ff[2];
         if (!opt_ff[2]) begin
            flag_in[2] = 1'b0;
         end else if (flag_ff[0]) begin
            flag_in[2] = latch_nx;
         end
         left_out_in  = latch_nx ? '0 : left_sel;
         right_out_in = latch_nx ? '0 : right_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         selected_ff  <= '0;
         left_cmd_ff  <= '0;
         right_cmd_ff <= '0;
         opt_ff       <= '0;
         stop_ff      <= STOP_RESET;
         resume_ff    <= RESUME_RESET;
         filt_ff      <= '0;
         flag_ff      <= '0;
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         latch_ff     <= 1'b0;
         left_out_ff  <= '0;
         right_out_ff <= '0;
      end else begin
         selected_ff  <= selected_in;
         left_cmd_ff  <= left_cmd_in;
         right_cmd_ff <= right_cmd_in;
         opt_ff       <= opt_in;
         stop_ff      <= stop_in;
         resume_ff    <= resume_in;
         filt_ff      <= filt_in;
         flag_ff      <= flag_in;
         pos_ff       <= pos_in;
         full_ff      <= full_in;
         latch_ff     <= latch_in;
         left_out_ff  <= left_out_in;
         right_out_ff <= right_out_in;
      end
   end

   // Sample ring and running sum; only written entries are ever summed.
   always_ff @(posedge clock) begin
      if (ctl_cmd.ring_store) begin
         ring_ff[pos_ff] <= sample_ff[DIST_W-1:0];
         sum_ff          <= '0;
         sum_idx_ff      <= '0;
      end else if (ctl_cmd.sum_step) begin
         sum_ff     <= sum_ff + SUM_W'(ring_ff[sum_idx_ff]);
         sum_idx_ff <= sum_idx_ff + 1'b1;
      end
   end

   rbrs_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl_cmd.div_start),
      .dividend (sum_ff),
      .divisor  (count),
      .done     (div_done),
      .quotient (quotient)
   );

   // Register read multiplexer.
   always_comb begin
      rd_len = LEN_TWO;
      unique case (selected_ff)
         REG_ID:     rd_data = ID_WORD;
         REG_LEFT:   rd_data = 16'(left_cmd_ff);
         REG_RIGHT:  rd_data = 16'(right_cmd_ff);
         REG_DIST:   rd_data = dist_wide;
         REG_FLAGS: begin
            rd_data = {13'd0, flag_ff};
            rd_len  = LEN_ONE;
         end
         REG_OPTS: begin
            rd_data = {8'd0, opt_ff};
            rd_len  = LEN_ONE;
         end
         REG_STOP:   rd_data = stop_ff;
         REG_RESUME: rd_data = resume_ff;
         default: begin
            rd_data = 16'd0;
            rd_len  = LEN_ONE;
         end
      endcase
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl_cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.load_rsp) begin
         rsp_data_ff  <= (cmd_ff == CMD_READ) ? rd_data : 16'd0;
         rsp_len_ff   <= (cmd_ff == CMD_READ) ? rd_len  : LEN_NONE;
         rsp_left_ff  <= left_out_ff;
         rsp_right_ff <= right_out_ff;
         rsp_flag_ff  <= flag_ff;
      end
   end

   // Status back to the controller.
   always_comb begin
      ctl_stat.cmd       = cmd_ff;
      ctl_stat.sample_ok = sample_ok;
      ctl_stat.sum_last  = ((CNT_W'(sum_idx_ff) + 1'b1) == count);
      ctl_stat.div_done  = div_done;
      ctl_stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_read_len    = rsp_len_ff;
   assign rsp_left_drive  = rsp_left_ff;
   assign rsp_right_drive = rsp_right_ff;
   assign rsp_status_bits = rsp_flag_ff;

endmodule

`default_nettype wire

// ----- hdl/rbrs_ctrl.sv -----
// Controller state machine that sequences one transaction at a time.
// Depends on rbrs_pkg; drives the datapath through its command struct.
`default_nettype none

module rbrs_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire rbrs_pkg::ctrl_status_type ctl_stat,
   output rbrs_pkg::ctrl_cmd_type         ctl_cmd
);

   import rbrs_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_DIVGO  = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0] state_ff, state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      ctl_cmd   = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl_cmd.capture = 1'b1;
               state_in        = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (ctl_stat.cmd)
               CMD_WRITE: begin
                  ctl_cmd.do_write = 1'b1;
                  state_in         = ST_OUT;
               end
               CMD_TICK: begin
                  if (ctl_stat.sample_ok) begin
                     ctl_cmd.ring_store = 1'b1;
                     state_in           = ST_SUM;
                  end else begin
                     ctl_cmd.dist_clear = 1'b1;
                     state_in           = ST_FINISH;
                  end
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_SUM: begin
            ctl_cmd.sum_step = 1'b1;
            if (ctl_stat.sum_last) begin
               state_in = ST_DIVGO;
            end
         end
         ST_DIVGO: begin
            ctl_cmd.div_start = 1'b1;
            state_in          = ST_DIV;
         end
         ST_DIV: begin
            if (ctl_stat.div_done) begin
               ctl_cmd.div_take = 1'b1;
               state_in         = ST_FINISH;
            end
         end
         ST_FINISH: begin
            ctl_cmd.finish = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (ctl_stat.rsp_free) begin
               ctl_cmd.load_rsp = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- verif/robot_bridge_response_checker.sv -----
// Response checker for the robot bridge register block: watches both channels,
// predicts every response from the accepted requests and compares field by field.
// Depends on rbrs_pkg and rbrs_if.
`timescale 1ns / 1ps

module robot_bridge_response_checker #(
   parameter int unsigned AVG_DEPTH = rbrs_pkg::AVG_DEPTH_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   rbrs_req_if         req_ch,
   rbrs_rsp_if         rsp_ch,
   output int unsigned mismatch_count,
   output int unsigned pending_count,
   output int unsigned checked_count
);
   import rbrs_pkg::*;

   typedef struct packed {
      logic [15:0]       read_data;
      logic [1:0]        read_len;
      logic signed [8:0] left_drive;
      logic signed [8:0] right_drive;
      logic [2:0]        status_bits;
   } bridge_response_type;

   // Predicted register file, filter and safety state.
   logic [7:0]        addr_sel;
   logic signed [8:0] speed_left;
   logic signed [8:0] speed_right;
   logic [7:0]        opt_bits;
   logic [15:0]       stop_mm;
   logic [15:0]       resume_mm;
   logic [15:0]       dist_avg;
   logic [2:0]        flags_now;
   logic [11:0]       ring_mm [AVG_DEPTH];
   int unsigned       ring_wr;
   logic              ring_wrapped;
   logic              halted;
   logic signed [8:0] drive_left;
   logic signed [8:0] drive_right;

   bridge_response_type awaited_responses [$];
   bridge_response_type oldest;

   task automatic clear_prediction();
      addr_sel     = REG_ID;
      speed_left   = '0;
      speed_right  = '0;
      opt_bits     = '0;
      stop_mm      = STOP_RESET;
      resume_mm    = RESUME_RESET;
      dist_avg     = '0;
      flags_now    = '0;
      foreach (ring_mm[i]) ring_mm[i] = '0;
      ring_wr      = 0;
      ring_wrapped = 1'b0;
      halted       = 1'b0;
      drive_left   = '0;
      drive_right  = '0;
   endtask

   // Speeds saturate symmetrically to the motor drive range.
   function automatic logic signed [8:0] saturate_speed(input logic [15:0] raw);
      int v;
      v = int'(signed'(raw));
      if (v > int'(DRIVE_MAX)) begin
         v = int'(DRIVE_MAX);
      end else if (v < -int'(DRIVE_MAX)) begin
         v = -int'(DRIVE_MAX);
      end
      return 9'(v);
   endfunction

   // Applies one request to the predicted state and forms the response it gives.
   function automatic bridge_response_type next_bridge_response(
      input logic [1:0]  cmd,
      input logic [7:0]  addr,
      input logic [1:0]  len,
      input logic [15:0] data,
      input logic [15:0] mm
   );
      bridge_response_type rsp;
      int unsigned sum;
      int unsigned count;
      rsp = '0;
      case (cmd)
         CMD_WRITE: begin
            addr_sel = addr;
            // The options register takes one byte; the rest need two or more.
            if (len != LEN_NONE) begin
               if (addr == REG_OPTS) begin
                  opt_bits = data[7:0];
               end else if (len != LEN_ONE) begin
                  case (addr)
                     REG_LEFT:   speed_left  = saturate_speed(data);
                     REG_RIGHT:  speed_right = saturate_speed(data);
                     REG_STOP:   stop_mm     = (data < STOP_MIN) ? STOP_MIN : data;
                     REG_RESUME: resume_mm   = (data < stop_mm) ? stop_mm : data;
                     default: ;
                  endcase
               end
            end
         end
         CMD_READ: begin
            rsp.read_len = LEN_TWO;
            case (addr_sel)
               REG_ID:     rsp.read_data = ID_WORD;
               REG_LEFT:   rsp.read_data = {{7{speed_left[8]}}, speed_left};
               REG_RIGHT:  rsp.read_data = {{7{speed_right[8]}}, speed_right};
               REG_DIST:   rsp.read_data = dist_avg;
               REG_STOP:   rsp.read_data = stop_mm;
               REG_RESUME: rsp.read_data = resume_mm;
               REG_FLAGS: begin
                  rsp.read_data = {13'd0, flags_now};
                  rsp.read_len  = LEN_ONE;
               end
               REG_OPTS: begin
                  rsp.read_data = {8'd0, opt_bits};
                  rsp.read_len  = LEN_ONE;
               end
               default: begin
                  rsp.read_data = '0;
                  rsp.read_len  = LEN_ONE;
               end
            endcase
         end
         CMD_TICK: begin
            // Out-of-range samples clear the distance but leave the ring alone.
            if (mm == 16'd0 || mm > SAMPLE_MAX) begin
               dist_avg     = '0;
               flags_now[0] = 1'b0;
            end else begin
               ring_mm[ring_wr] = mm[11:0];
               ring_wr++;
               if (ring_wr >= AVG_DEPTH) begin
                  ring_wr      = 0;
                  ring_wrapped = 1'b1;
               end
               count = ring_wrapped ? AVG_DEPTH : ring_wr;
               sum   = 0;
               for (int unsigned i = 0; i < count; i++) sum += ring_mm[i];
               dist_avg     = 16'(sum / count);
               flags_now[0] = 1'b1;
            end
            // Hysteresis stop latch: cleared while the safety stop is off, else only moved by a valid distance.
            if (!opt_bits[2]) begin
               flags_now[2:1] = 2'b00;
               halted         = 1'b0;
            end else begin
               flags_now[1] = 1'b1;
               if (flags_now[0]) begin
                  if (!halted) begin
                     if (dist_avg <= stop_mm) halted = 1'b1;
                  end else if (dist_avg >= resume_mm) begin
                     halted = 1'b0;
                  end
                  flags_now[2] = halted;
               end
            end
            drive_left  = opt_bits[0] ? -speed_left : speed_left;
            drive_right = opt_bits[1] ? -speed_right : speed_right;
            if (halted) begin
               drive_left  = '0;
               drive_right = '0;
            end
         end
         default: ;
      endcase
      rsp.left_drive  = drive_left;
      rsp.right_drive = drive_right;
      rsp.status_bits = flags_now;
      return rsp;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         clear_prediction();
         awaited_responses.delete();
         mismatch_count = 0;
         checked_count  = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_responses.size() == 0) begin
               $error("response transaction with no request outstanding");
               mismatch_count++;
            end else begin
               oldest = awaited_responses.pop_front();
               checked_count++;
               check_field("read_data", int'(oldest.read_data), int'(rsp_ch.read_data));
               check_field("read_len", int'(oldest.read_len), int'(rsp_ch.read_len));
               check_field("left_drive", int'(oldest.left_drive), int'(rsp_ch.left_drive));
               check_field("right_drive", int'(oldest.right_drive),
                           int'(rsp_ch.right_drive));
               check_field("status_bits", int'(oldest.status_bits),
                           int'(rsp_ch.status_bits));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            awaited_responses.push_back(next_bridge_response(req_ch.cmd, req_ch.reg_addr,
               req_ch.write_len, req_ch.write_data, req_ch.sample_mm));
         end
      end
      pending_count = awaited_responses.size();
   end

endmodule

// ----- verif/robot_bridge_registers_with_safety_core_test.sv -----
// Testbench top for the robot bridge register block: drives directed and random
// bus and sensor transactions, stalls the response side and gives the verdict.
// Depends on rbrs_pkg, rbrs_if, the block itself and robot_bridge_response_checker.
`timescale 1ns / 1ps

module robot_bridge_registers_with_safety_core_test;
   import rbrs_pkg::*;

   localparam logic [1:0]  CMD_UNUSED   = 2'd3;
   localparam logic [1:0]  LEN_MANY     = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 900;
   localparam int unsigned QUIET_LIMIT  = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        calm  = 1'b0;
   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned sent_writes  = 0;
   int unsigned sent_reads   = 0;
   int unsigned sent_ticks   = 0;
   int unsigned sent_unused  = 0;

   rbrs_req_if req_ch ();
   rbrs_rsp_if rsp_ch ();

   robot_bridge_registers_with_safety_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   robot_bridge_response_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random, except during the calm stretch.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= calm || ($urandom_range(99) >= 13);
      end
   end

   // Ends the run when no transaction moves for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

   // Presents one request and returns once it has been accepted.
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] addr,
                               input logic [1:0] len, input logic [15:0] data,
                               input logic [15:0] mm);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 13) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= cmd;
      req_ch.reg_addr   <= addr;
      req_ch.write_len  <= len;
      req_ch.write_data <= data;
      req_ch.sample_mm  <= mm;
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
      case (cmd)
         CMD_WRITE: sent_writes++;
         CMD_READ:  sent_reads++;
         CMD_TICK:  sent_ticks++;
         default:   sent_unused++;
      endcase
   endtask

   task automatic bus_write(input logic [7:0] addr, input logic [1:0] len,
                            input logic [15:0] data);
      send_request(CMD_WRITE, addr, len, data, 16'($urandom));
   endtask

   task automatic bus_read();
      send_request(CMD_READ, 8'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic sensor_tick(input logic [15:0] mm);
      send_request(CMD_TICK, 8'($urandom), 2'($urandom), 16'($urandom), mm);
   endtask

   // Lowers valid and holds off until every expected response has arrived.
   task automatic drain_responses();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Samples cluster around the thresholds so that the stop latch moves often.
   function automatic logic [15:0] random_sample();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         return 16'($urandom_range(600, 20));
      end else if (pick < 85) begin
         return 16'($urandom_range(4000, 1));
      end else if (pick < 92) begin
         return 16'($urandom_range(65535, 4001));
      end else if (pick < 95) begin
         return 16'd0;
      end else begin
         return $urandom_range(1) ? SAMPLE_MAX : 16'd1;
      end
   endfunction

   // Mostly well-formed register traffic and ticks, with some noise.
   task automatic random_transaction();
      int unsigned pick;
      logic [7:0]  addr;
      logic [1:0]  len;
      logic [15:0] data;
      pick = $urandom_range(99);
      len  = ($urandom_range(9) < 7) ? LEN_TWO : 2'($urandom);
      data = 16'($urandom);
      if (pick < 45) begin
         sensor_tick(random_sample());
      end else if (pick < 67) begin
         case ($urandom_range(7))
            0: addr = REG_ID;
            1: addr = REG_LEFT;
            2: addr = REG_RIGHT;
            3: addr = REG_DIST;
            4: addr = REG_FLAGS;
            5: addr = REG_OPTS;
            6: addr = REG_STOP;
            default: addr = REG_RESUME;
         endcase
         case (addr)
            REG_LEFT, REG_RIGHT: begin
               if ($urandom_range(1)) data = 16'($urandom_range(600)) - 16'd300;
            end
            REG_OPTS:   if ($urandom_range(3) != 0) data[2] = 1'b1;
            REG_STOP:   data = 16'($urandom_range(400));
            REG_RESUME: data = 16'($urandom_range(700));
            default: ;
         endcase
         bus_write(addr, len, data);
      end else if (pick < 90) begin
         bus_read();
      end else if (pick < 97) begin
         bus_write(8'($urandom), 2'($urandom), data);
      end else begin
         send_request(CMD_UNUSED, 8'($urandom), 2'($urandom), data, 16'($urandom));
      end
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.cmd        = CMD_WRITE;
      req_ch.reg_addr   = '0;
      req_ch.write_len  = LEN_NONE;
      req_ch.write_data = '0;
      req_ch.sample_mm  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Identity after reset, speed saturation at both ends, short and over-long writes.
      bus_read();
      bus_write(REG_LEFT, LEN_TWO, 16'h7FFF);
      bus_read();
      bus_write(REG_LEFT, LEN_TWO, 16'h8000);
      bus_read();
      bus_write(REG_RIGHT, LEN_ONE, 16'h0064);
      bus_write(REG_RIGHT, LEN_MANY, 16'h0064);
      bus_read();
      // Threshold floors, then a working stop and resume pair.
      bus_write(REG_STOP, LEN_TWO, 16'd5);
      bus_write(REG_RESUME, LEN_TWO, 16'd0);
      bus_read();
      bus_write(REG_STOP, LEN_TWO, 16'd200);
      bus_write(REG_RESUME, LEN_TWO, 16'd300);
      // Both inversions and the safety stop on; the high byte is ignored.
      bus_write(REG_OPTS, LEN_ONE, 16'hFF07);
      // Invalid samples, the range limits, then a close object and its removal.
      sensor_tick(16'd0);
      sensor_tick(16'd4001);
      sensor_tick(16'hFFFF);
      sensor_tick(SAMPLE_MAX);
      sensor_tick(16'd1);
      sensor_tick(16'd100);
      sensor_tick(16'd0);
      repeat (4) sensor_tick(SAMPLE_MAX);
      // Read-only and unknown registers, the unused command, select-only access.
      bus_write(REG_DIST, LEN_TWO, 16'h1234);
      bus_read();
      bus_write(8'hFF, LEN_TWO, 16'hFFFF);
      bus_read();
      send_request(CMD_UNUSED, 8'hFF, LEN_MANY, 16'hFFFF, 16'hFFFF);
      bus_write(REG_OPTS, LEN_NONE, 16'h00FF);
      bus_read();
      bus_write(REG_OPTS, LEN_TWO, 16'h0000);
      sensor_tick(16'd100);
      drain_responses();

      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 300 && n < 500);
         if ($urandom_range(99) < 2) drain_responses();
         random_transaction();
      end
      drain_responses();
      repeat (20) @(posedge clock);

      $display("run covered %0d bus writes, %0d bus reads, %0d sensor ticks, %0d unused",
               sent_writes, sent_reads, sent_ticks, sent_unused);
      $display("%0d responses compared against the prediction, %0d mismatches",
               checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
